>>> src/tvs_pkg.sv
// Shared constants, payload structs and helper functions for the trilinear volume sampler.
// No dependencies; every other file in src imports this package.
package tvs_pkg;

   localparam int MAX_DIM    = 32;
   localparam int DIM_BITS   = $clog2(MAX_DIM);
   localparam int SIZE_BITS  = DIM_BITS + 1;
   localparam int ADDR_BITS  = 3 * DIM_BITS;
   localparam int FRAC_BITS  = 8;
   localparam int VALUE_BITS = 16;
   localparam int RAW_BITS   = 8;
   localparam int KIND_BITS  = 2;
   localparam int CSR_IDX_BITS = 2;

   // weight widths: one axis weight spans 0..2^FRAC_BITS
   localparam int WGT_BITS  = FRAC_BITS + 1;
   localparam int WXY_BITS  = 2 * FRAC_BITS + 1;
   localparam int W3_BITS   = 3 * FRAC_BITS + 1;
   localparam int SHIFT     = 3 * FRAC_BITS;
   // weights sum to 2^SHIFT, so the 8-term sum stays inside one product width
   localparam int ACC_BITS  = VALUE_BITS + W3_BITS + 1;
   localparam int CORNERS   = 8;
   localparam int CNT_BITS  = $clog2(CORNERS);

   localparam int unsigned ONE_VAL = 1 << FRAC_BITS;
   localparam logic [WGT_BITS-1:0] W_ONE = WGT_BITS'(ONE_VAL);
   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'd1 << (SHIFT - 1));
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_DIM);

   localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RAW   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_Z = 2'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic [DIM_BITS-1:0]          voxel_x;
      logic [DIM_BITS-1:0]          voxel_y;
      logic [DIM_BITS-1:0]          voxel_z;
      logic signed [VALUE_BITS-1:0] density_in;
      logic signed [VALUE_BITS-1:0] temperature_in;
      logic signed [VALUE_BITS-1:0] query_x;
      logic signed [VALUE_BITS-1:0] query_y;
      logic signed [VALUE_BITS-1:0] query_z;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] density_out;
      logic signed [VALUE_BITS-1:0] temperature_out;
      logic signed [RAW_BITS-1:0]   raw_density;
      logic                         in_range;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] dens;
      logic signed [VALUE_BITS-1:0] temp;
   } voxel_type;

   // one corner handed to the multiply-accumulate unit
   typedef struct packed {
      logic                valid;
      logic [WGT_BITS-1:0] wx;
      logic [WGT_BITS-1:0] wy;
      logic [WGT_BITS-1:0] wz;
   } mac_issue_type;

   // zero reads as one, anything above the grid as the full grid
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      if (s == '0) r = SIZE_BITS'(1);
      else if (s > SIZE_BITS'(MAX_DIM)) r = SIZE_BITS'(MAX_DIM);
      else r = s;
      return r;
   endfunction

endpackage

>>> src/tvs_store.sv
// Voxel store: single-port memory with registered read data, one access per cycle.
// Depends on tvs_pkg.
module tvs_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic                      rd_en,
   input  logic [tvs_pkg::ADDR_BITS-1:0] addr,
   input  tvs_pkg::voxel_type        wr_data,
   output tvs_pkg::voxel_type        rd_data
);
   import tvs_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   voxel_type mem [DEPTH];
   voxel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tvs_mac.sv
// Shared weight/multiply-accumulate unit: three stages per corner (weight product,
// full weight with aligned store data, accumulate). Depends on tvs_pkg.
module tvs_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  tvs_pkg::mac_issue_type             issue,
   input  tvs_pkg::voxel_type                 rd_data,
   output logic signed [tvs_pkg::VALUE_BITS-1:0] dens_out,
   output logic signed [tvs_pkg::VALUE_BITS-1:0] temp_out
);
   import tvs_pkg::*;

   logic                      v1_ff, v2_ff;
   logic [WXY_BITS-1:0]       wxy_ff;
   logic [WGT_BITS-1:0]       wz_ff;
   logic [W3_BITS-1:0]        w_ff;
   voxel_type                 data_ff;
   logic signed [ACC_BITS-1:0] acc_d_ff, acc_t_ff;

   logic [2*WGT_BITS-1:0]          wxy_full;
   logic [WXY_BITS+WGT_BITS-1:0]   w_full;
   logic signed [ACC_BITS-1:0]     prod_d, prod_t;

   always_comb begin
      wxy_full = issue.wx * issue.wy;
      w_full   = wxy_ff * wz_ff;
      prod_d   = data_ff.dens * $signed({1'b0, w_ff});
      prod_t   = data_ff.temp * $signed({1'b0, w_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue.valid;
         v2_ff <= v1_ff;
      end
      if (issue.valid) begin
         wxy_ff <= wxy_full[WXY_BITS-1:0];
         wz_ff  <= issue.wz;
      end
      // store data for the corner issued last cycle is valid now
      if (v1_ff) begin
         w_ff    <= w_full[W3_BITS-1:0];
         data_ff <= rd_data;
      end
      if (clear) begin
         acc_d_ff <= '0;
         acc_t_ff <= '0;
      end else if (v2_ff) begin
         acc_d_ff <= acc_d_ff + prod_d;
         acc_t_ff <= acc_t_ff + prod_t;
      end
   end

   // round half up, arithmetic shift, saturate
   function automatic logic signed [VALUE_BITS-1:0] round_sat(input logic signed [ACC_BITS-1:0] a);
      logic signed [ACC_BITS-1:0] rnd;
      logic signed [ACC_BITS-1:0] sh;
      logic [VALUE_BITS-1:0]      r;
      rnd = a + $signed(ROUND_HALF);
      sh  = rnd >>> SHIFT;
      if ((&sh[ACC_BITS-1:VALUE_BITS-1]) || !(|sh[ACC_BITS-1:VALUE_BITS-1]))
         r = sh[VALUE_BITS-1:0];
      else if (sh[ACC_BITS-1])
         r = {1'b1, {(VALUE_BITS-1){1'b0}}};
      else
         r = {1'b0, {(VALUE_BITS-1){1'b1}}};
      return $signed(r);
   endfunction

   assign dens_out = round_sat(acc_d_ff);
   assign temp_out = round_sat(acc_t_ff);

endmodule

>>> src/trilinear_volume_sampler_core.sv
// Top level of the trilinear volume sampler: request decode, corner sequencer, size
// registers and result register. Depends on tvs_pkg, tvs_store and tvs_mac.
//
// Usage:
//  - req channel (valid/ready) carries one item: load, interpolated query or raw read.
//    A load writes one voxel in the accept cycle and produces no result; kind three is
//    dropped the same way.
//  - rsp channel (valid/ready) returns one result per query or raw read.
//  - csr port writes size_x/size_y/size_z (index 0..2) with no handshake; only while idle.
//  - A query in range runs from accept to result register as eight corner reads on the
//    single-port store, one per cycle, then the three-stage multiply-accumulate unit
//    draining and the finish step. An out-of-range query or a raw read goes straight to
//    the finish step (a raw read's store read overlaps the accept). req_ready is high
//    only while the sequencer is idle, so a new query or raw read is accepted only once
//    the last one is through the finish step; loads leave it idle, one load per cycle.
//  - Results land in an output register; the next item is accepted while it waits. If
//    the receiver stalls with a result still held, the sequencer waits in its finish step.
//  - Reset clears the sequencer and result valid and sets all sizes to 32. The store is
//    not cleared: a voxel must be loaded before it is read.
module trilinear_volume_sampler_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tvs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tvs_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [tvs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [tvs_pkg::SIZE_BITS-1:0]   csr_wdata
);
   import tvs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic [KIND_BITS-1:0] kind_ff;
   logic                 inr_ff;
   logic [DIM_BITS-1:0]  lx_ff, ly_ff, lz_ff, hx_ff, hy_ff, hz_ff;
   logic [FRAC_BITS-1:0] tx_ff, ty_ff, tz_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic [SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;

   logic [SIZE_BITS-1:0] sx, sy, sz;
   logic [DIM_BITS-1:0]  mx, my, mz;
   logic                 req_fire, vox_in, q_in;
   logic [DIM_BITS-1:0]  qlx, qly, qlz;
   logic                 st_wr, st_rd;
   logic [ADDR_BITS-1:0] st_addr;
   voxel_type            st_wdata, st_rdata;
   mac_issue_type        issue;
   logic signed [VALUE_BITS-1:0] mac_dens, mac_temp;
   logic [VALUE_BITS:0]  raw_mag;
   logic [VALUE_BITS-FRAC_BITS:0] raw_int;
   logic [RAW_BITS-1:0]  raw_val;
   rsp_type              fin_data;

   function automatic logic q_inside(input logic signed [VALUE_BITS-1:0] q,
                                     input logic [DIM_BITS-1:0] m);
      logic [VALUE_BITS-2:0] lim;
      lim = {{(VALUE_BITS-1-DIM_BITS-FRAC_BITS){1'b0}}, m, {FRAC_BITS{1'b0}}};
      return !q[VALUE_BITS-1] && (q[VALUE_BITS-2:0] <= lim);
   endfunction

   function automatic logic [DIM_BITS-1:0] upper(input logic [DIM_BITS-1:0] lo,
                                                  input logic [DIM_BITS-1:0] m);
      return (lo == m) ? lo : lo + DIM_BITS'(1);
   endfunction

   function automatic logic [WGT_BITS-1:0] weight(input logic sel,
                                                   input logic [FRAC_BITS-1:0] t);
      return sel ? {1'b0, t} : W_ONE - {1'b0, t};
   endfunction

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            CSR_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sx = eff_size(size_x_ff);
      sy = eff_size(size_y_ff);
      sz = eff_size(size_z_ff);
      mx = DIM_BITS'(sx - SIZE_BITS'(1));
      my = DIM_BITS'(sy - SIZE_BITS'(1));
      mz = DIM_BITS'(sz - SIZE_BITS'(1));
      req_fire = req_valid && req_ready;
      vox_in = ({1'b0, req_data.voxel_x} < sx) && ({1'b0, req_data.voxel_y} < sy) &&
               ({1'b0, req_data.voxel_z} < sz);
      q_in = q_inside(req_data.query_x, mx) && q_inside(req_data.query_y, my) &&
             q_inside(req_data.query_z, mz);
      qlx = req_data.query_x[FRAC_BITS +: DIM_BITS];
      qly = req_data.query_y[FRAC_BITS +: DIM_BITS];
      qlz = req_data.query_z[FRAC_BITS +: DIM_BITS];
   end

   // store port: loads and raw reads in the accept cycle, corner reads while issuing
   always_comb begin
      st_wr = req_fire && (req_data.kind == KIND_LOAD) && vox_in;
      st_rd = (req_fire && (req_data.kind == KIND_RAW) && vox_in) || (state_ff == S_ISSUE);
      st_wdata.dens = req_data.density_in;
      st_wdata.temp = req_data.temperature_in;
      if (state_ff == S_ISSUE)
         st_addr = {cnt_ff[2] ? hz_ff : lz_ff, cnt_ff[1] ? hy_ff : ly_ff,
                    cnt_ff[0] ? hx_ff : lx_ff};
      else
         st_addr = {req_data.voxel_z, req_data.voxel_y, req_data.voxel_x};
      issue.valid = (state_ff == S_ISSUE);
      issue.wx = weight(cnt_ff[0], tx_ff);
      issue.wy = weight(cnt_ff[1], ty_ff);
      issue.wz = weight(cnt_ff[2], tz_ff);
   end

   tvs_store u_store (
      .clock   (clock),
      .wr_en   (st_wr),
      .rd_en   (st_rd),
      .addr    (st_addr),
      .wr_data (st_wdata),
      .rd_data (st_rdata)
   );

   tvs_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (req_fire),
      .issue    (issue),
      .rd_data  (st_rdata),
      .dens_out (mac_dens),
      .temp_out (mac_temp)
   );

   // raw read: truncate toward zero, wrap to the 8-bit field; then build the finish result
   always_comb begin
      if (st_rdata.dens[VALUE_BITS-1])
         raw_mag = (VALUE_BITS+1)'(0) - {1'b1, st_rdata.dens};
      else
         raw_mag = {1'b0, st_rdata.dens};
      raw_int = raw_mag[VALUE_BITS:FRAC_BITS];
      if (st_rdata.dens[VALUE_BITS-1])
         raw_int = (VALUE_BITS-FRAC_BITS+1)'(0) - raw_int;
      raw_val = raw_int[RAW_BITS-1:0];

      fin_data = '0;
      if (inr_ff) begin
         fin_data.in_range = 1'b1;
         if (kind_ff == KIND_QUERY) begin
            fin_data.density_out     = mac_dens;
            fin_data.temperature_out = mac_temp;
         end else begin
            fin_data.raw_density = $signed(raw_val);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the finish step reloads the result register itself
         if (rsp_ready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_fire) begin
                  kind_ff <= req_data.kind;
                  lx_ff <= qlx;
                  ly_ff <= qly;
                  lz_ff <= qlz;
                  hx_ff <= upper(qlx, mx);
                  hy_ff <= upper(qly, my);
                  hz_ff <= upper(qlz, mz);
                  tx_ff <= req_data.query_x[FRAC_BITS-1:0];
                  ty_ff <= req_data.query_y[FRAC_BITS-1:0];
                  tz_ff <= req_data.query_z[FRAC_BITS-1:0];
                  priority if (req_data.kind == KIND_QUERY) begin
                     inr_ff   <= q_in;
                     state_ff <= q_in ? S_ISSUE : S_FINISH;
                  end else if (req_data.kind == KIND_RAW) begin
                     inr_ff   <= vox_in;
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_ISSUE: begin
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(CORNERS - 1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // let the last corner pass the data and accumulate stages into the accumulators
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= fin_data;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_query: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.kind == KIND_QUERY) |=> !req_ready)
      else $error("sequencer accepted a query without leaving idle");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.kind == KIND_LOAD) |=> (state_ff == S_IDLE) && req_ready)
      else $error("load started a sequence");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_range |->
         (rsp_data.density_out == '0) && (rsp_data.temperature_out == '0) &&
         (rsp_data.raw_density == '0))
      else $error("out-of-range result carries data");

   a_raw_no_interp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.raw_density != '0) |->
         (rsp_data.density_out == '0) && (rsp_data.temperature_out == '0))
      else $error("raw result mixed with interpolated data");
`endif

endmodule

>>> test/tb_trilinear_volume_sampler_core.sv
// Self-checking testbench for trilinear_volume_sampler_core: voxel loads, interpolated
// queries and raw reads over several grid sizes, checked against an in-bench predictor.
// Depends on tvs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_trilinear_volume_sampler_core;
   import tvs_pkg::*;

   localparam int UNIT = 1 << FRAC_BITS;
   localparam int SUM_SHIFT = 3 * FRAC_BITS;
   localparam longint VALUE_MAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN = -VALUE_MAX - 1;
   localparam int VOXELS = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0] csr_wdata;

   // predictor state
   logic [VALUE_BITS-1:0] density_mem [VOXELS];
   logic [VALUE_BITS-1:0] temperature_mem [VOXELS];
   bit loaded [VOXELS];
   logic [SIZE_BITS-1:0] size_reg [3];
   int corner_addr [8];
   longint corner_weight [8];
   rsp_type pending_samples [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int errors = 0;
   int n_loads = 0;
   int n_queries = 0;
   int n_raw = 0;
   int n_checked = 0;
   int n_inside = 0;
   int unsigned cycle_count = 0;
   rsp_type want;

   trilinear_volume_sampler_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_samples.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int dim_in_use(input logic [SIZE_BITS-1:0] s);
      if (s == 0) return 1;
      if (s > MAX_DIM) return MAX_DIM;
      return int'(s);
   endfunction

   function automatic int voxel_index(input int x, input int y, input int z);
      return (z * MAX_DIM + y) * MAX_DIM + x;
   endfunction

   // -1 when the integer coordinates fall outside the grid in use
   function automatic int raw_voxel(input req_type it);
      if (it.voxel_x >= dim_in_use(size_reg[0]) || it.voxel_y >= dim_in_use(size_reg[1]) ||
          it.voxel_z >= dim_in_use(size_reg[2]))
         return -1;
      return voxel_index(it.voxel_x, it.voxel_y, it.voxel_z);
   endfunction

   // fills corner_addr/corner_weight; corner n takes the upper index on axis k if bit k set
   function automatic bit locate_query(input req_type it);
      int q [3];
      int dim [3];
      int lo [3];
      int hi [3];
      int frac [3];
      int c [3];
      longint wa [3];
      q[0] = $signed(it.query_x);
      q[1] = $signed(it.query_y);
      q[2] = $signed(it.query_z);
      for (int k = 0; k < 3; k++) begin
         dim[k] = dim_in_use(size_reg[k]);
         if (q[k] < 0 || q[k] > (dim[k] - 1) * UNIT) return 1'b0;
         lo[k] = q[k] / UNIT;
         frac[k] = q[k] % UNIT;
         hi[k] = (lo[k] + 1 < dim[k]) ? lo[k] + 1 : dim[k] - 1;
      end
      for (int n = 0; n < 8; n++) begin
         for (int k = 0; k < 3; k++) begin
            if (((n >> k) & 1) != 0) begin
               c[k] = hi[k];
               wa[k] = frac[k];
            end else begin
               c[k] = lo[k];
               wa[k] = UNIT - frac[k];
            end
         end
         corner_addr[n] = voxel_index(c[0], c[1], c[2]);
         corner_weight[n] = wa[0] * wa[1] * wa[2];
      end
      return 1'b1;
   endfunction

   function automatic logic [VALUE_BITS-1:0] round_to_value(input longint acc);
      longint r;
      r = (acc + (longint'(1) <<< (SUM_SHIFT - 1))) >>> SUM_SHIFT;
      if (r > VALUE_MAX) r = VALUE_MAX;
      if (r < VALUE_MIN) r = VALUE_MIN;
      return r[VALUE_BITS-1:0];
   endfunction

   // applies one accepted item to the predicted store; returns 1 if a result is due
   function automatic bit predict_sample(input req_type it, output rsp_type r);
      longint dacc;
      longint tacc;
      int a;
      int d;
      int ip;
      r = '0;
      dacc = 0;
      tacc = 0;
      case (it.kind)
         KIND_LOAD: begin
            a = raw_voxel(it);
            if (a >= 0) begin
               density_mem[a] = it.density_in;
               temperature_mem[a] = it.temperature_in;
               loaded[a] = 1'b1;
            end
            return 1'b0;
         end
         KIND_QUERY: begin
            if (locate_query(it)) begin
               for (int n = 0; n < 8; n++) begin
                  dacc += longint'($signed(density_mem[corner_addr[n]])) * corner_weight[n];
                  tacc += longint'($signed(temperature_mem[corner_addr[n]])) * corner_weight[n];
               end
               r.density_out = round_to_value(dacc);
               r.temperature_out = round_to_value(tacc);
               r.in_range = 1'b1;
            end
            return 1'b1;
         end
         KIND_RAW: begin
            a = raw_voxel(it);
            if (a >= 0) begin
               d = int'($signed(density_mem[a]));
               // truncate toward zero, then wrap to the raw field
               ip = (d < 0) ? -((-d) >> FRAC_BITS) : (d >> FRAC_BITS);
               r.raw_density = ip[RAW_BITS-1:0];
               r.in_range = 1'b1;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- result side

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string label, input logic [VALUE_BITS-1:0] exp_val,
                              input logic [VALUE_BITS-1:0] got_val);
      if (got_val !== exp_val) begin
         errors++;
         $display("%0t %s mismatch: expected %h, got %h", $time, label, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            errors++;
            $display("%0t result with nothing expected: %h", $time, rsp_data);
         end else begin
            want = pending_samples.pop_front();
            check_field("density_out", want.density_out, rsp_data.density_out);
            check_field("temperature_out", want.temperature_out, rsp_data.temperature_out);
            check_field("raw_density", want.raw_density, rsp_data.raw_density);
            check_field("in_range", want.in_range, rsp_data.in_range);
            n_checked++;
            if (want.in_range) n_inside++;
         end
      end
   end

   // ---------------------------------------------------------------- request side

   task automatic send_item(input req_type it);
      rsp_type r;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid = 1'b1;
      req_data = it;
      do @(posedge clock); while (!req_ready);
      if (predict_sample(it, r)) pending_samples.push_back(r);
      case (it.kind)
         KIND_LOAD: n_loads++;
         KIND_QUERY: n_queries++;
         KIND_RAW: n_raw++;
         default: ;
      endcase
   endtask

   function automatic req_type random_bits();
      req_type it;
      it.kind = $urandom_range(3);
      it.voxel_x = $urandom_range(MAX_DIM - 1);
      it.voxel_y = $urandom_range(MAX_DIM - 1);
      it.voxel_z = $urandom_range(MAX_DIM - 1);
      it.density_in = $urandom_range(65535);
      it.temperature_in = $urandom_range(65535);
      it.query_x = $urandom_range(65535);
      it.query_y = $urandom_range(65535);
      it.query_z = $urandom_range(65535);
      return it;
   endfunction

   function automatic req_type load_item(input int x, input int y, input int z,
                                         input logic [15:0] dens, input logic [15:0] temp);
      req_type it;
      it = random_bits();
      it.kind = KIND_LOAD;
      it.voxel_x = x;
      it.voxel_y = y;
      it.voxel_z = z;
      it.density_in = dens;
      it.temperature_in = temp;
      return it;
   endfunction

   function automatic req_type query_item(input logic [15:0] qx, input logic [15:0] qy,
                                          input logic [15:0] qz);
      req_type it;
      it = random_bits();
      it.kind = KIND_QUERY;
      it.query_x = qx;
      it.query_y = qy;
      it.query_z = qz;
      return it;
   endfunction

   function automatic req_type raw_item(input int x, input int y, input int z);
      req_type it;
      it = random_bits();
      it.kind = KIND_RAW;
      it.voxel_x = x;
      it.voxel_y = y;
      it.voxel_z = z;
      return it;
   endfunction

   task automatic fill_voxel(input int a);
      send_item(load_item(a % MAX_DIM, (a / MAX_DIM) % MAX_DIM, a / (MAX_DIM * MAX_DIM),
                          $urandom_range(65535), $urandom_range(65535)));
   endtask

   // any voxel the item will read gets loaded first, so the store is never read unwritten
   task automatic issue(input req_type it);
      int a;
      if (it.kind == KIND_QUERY && locate_query(it)) begin
         for (int n = 0; n < 8; n++)
            if (!loaded[corner_addr[n]]) fill_voxel(corner_addr[n]);
      end else if (it.kind == KIND_RAW) begin
         a = raw_voxel(it);
         if (a >= 0 && !loaded[a]) fill_voxel(a);
      end
      send_item(it);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      size_reg[idx] = val;
   endtask

   task automatic set_grid(input logic [SIZE_BITS-1:0] sx, input logic [SIZE_BITS-1:0] sy,
                           input logic [SIZE_BITS-1:0] sz);
      drain_results();
      write_size(CSR_SIZE_X, sx);
      write_size(CSR_SIZE_Y, sy);
      write_size(CSR_SIZE_Z, sz);
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(63);
      if (r < 20) return MAX_DIM;
      return $urandom_range(1, 6);
   endfunction

   function automatic req_type random_item();
      req_type it;
      int r;
      int dx;
      int dy;
      int dz;
      it = random_bits();
      r = $urandom_range(99);
      dx = dim_in_use(size_reg[0]);
      dy = dim_in_use(size_reg[1]);
      dz = dim_in_use(size_reg[2]);
      if (r < 15) begin
         it.kind = KIND_LOAD;
         if ($urandom_range(9) != 0) begin
            it.voxel_x = $urandom_range(dx - 1);
            it.voxel_y = $urandom_range(dy - 1);
            it.voxel_z = $urandom_range(dz - 1);
         end
      end else if (r < 55) begin
         it.kind = KIND_QUERY;
         it.query_x = $urandom_range((dx - 1) * UNIT);
         it.query_y = $urandom_range((dy - 1) * UNIT);
         it.query_z = $urandom_range((dz - 1) * UNIT);
      end else if (r < 80) begin
         it.kind = KIND_RAW;
         it.voxel_x = $urandom_range(dx - 1);
         it.voxel_y = $urandom_range(dy - 1);
         it.voxel_z = $urandom_range(dz - 1);
      end
      // remaining items keep every field random: mostly out of range, kind three too
      return it;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      req_type it;
      send_idle_pct = 34;
      recv_idle_pct = 78;
      issue(load_item(0, 0, 0, 16'h7FFF, 16'h8000));
      issue(load_item(1, 0, 0, 16'h8000, 16'h7FFF));
      issue(load_item(2, 0, 0, 16'hFFFF, 16'h0000));
      issue(load_item(3, 0, 0, 16'hFE80, 16'h0001));
      issue(raw_item(0, 0, 0));
      issue(raw_item(1, 0, 0));
      issue(raw_item(2, 0, 0));       // -1/256 truncates to zero
      issue(raw_item(3, 0, 0));       // -1.5 truncates to -1
      issue(query_item(16'h0080, 16'h0000, 16'h0000));
      issue(query_item(16'h0000, 16'h0000, 16'h0000));
      issue(query_item(16'h1F00, 16'h1F00, 16'h1F00));   // far corner, upper index clamped
      issue(query_item(16'h1EFF, 16'h00FF, 16'h1E80));
      issue(query_item(16'h1F01, 16'h0000, 16'h0000));   // just past the edge
      issue(query_item(16'h0000, 16'hFFFF, 16'h0000));
      issue(query_item(16'h0000, 16'h0000, 16'h8000));
      issue(query_item(16'h7FFF, 16'h7FFF, 16'h7FFF));
      issue(raw_item(31, 31, 31));
      it = random_bits();
      it.kind = KIND_SPARE;
      issue(it);
      issue(raw_item(0, 0, 0));
   endtask

   task automatic test_grid_sizes();
      // zero reads as one, oversize as the full grid
      set_grid(6'd0, 6'd63, 6'd33);
      issue(query_item(16'h0000, 16'h1F00, 16'h0A80));
      issue(query_item(16'h0001, 16'h0000, 16'h0000));
      issue(raw_item(1, 0, 0));
      issue(raw_item(0, 31, 31));
      set_grid(6'd1, 6'd1, 6'd1);
      issue(load_item(1, 0, 0, 16'h1234, 16'h4321));   // outside, must not land
      issue(raw_item(0, 0, 0));
      issue(query_item(16'h0000, 16'h0000, 16'h0000));
      issue(query_item(16'h0000, 16'h0000, 16'h0001));
      set_grid(6'd32, 6'd2, 6'd31);
      issue(raw_item(1, 0, 0));
      issue(query_item(16'h1F00, 16'h0100, 16'h1E00));
      issue(query_item(16'h0000, 16'h0101, 16'h0000));
      issue(raw_item(0, 2, 0));
      issue(raw_item(0, 0, 31));
   endtask

   task automatic test_random_traffic(input int sp, input int rp, input int count);
      send_idle_pct = sp;
      recv_idle_pct = rp;
      for (int g = 0; g < 4; g++) begin
         set_grid(pick_size(), pick_size(), pick_size());
         for (int i = 0; i < count / 4; i++) issue(random_item());
      end
   endtask

   // receiver holds off while queries keep coming, so the core fills and stalls req
   task automatic test_result_backpressure();
      set_grid(6'd4, 6'd3, 6'd5);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 300;
      for (int i = 0; i < 24; i++)
         issue(query_item($urandom_range(3 * UNIT), $urandom_range(2 * UNIT),
                          $urandom_range(4 * UNIT)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_SIZE_X;
      csr_wdata = '0;
      for (int k = 0; k < 3; k++) size_reg[k] = SIZE_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_grid_sizes();
      test_random_traffic(34, 78, 460);
      test_random_traffic(78, 34, 460);
      test_random_traffic(0, 0, 460);
      test_result_backpressure();
      drain_results();
      repeat (30) @(posedge clock);

      $display("Covered %0d voxel loads, %0d interpolated queries and %0d raw reads",
               n_loads, n_queries, n_raw);
      $display("on grids of 1 to 32 voxels per axis; %0d results checked, %0d inside the grid.",
               n_checked, n_inside);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
